>>> hdl/spra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spra_pkg
// Shared types and constants for the stereo point reprojection averager.
// ----------------------------------------------------------------------------
package spra_pkg;

    localparam int DefMaxPoints   = 64;
    localparam int DefCoefFrac    = 16;
    localparam int NUM_REGS       = 8;
    localparam int REG_W          = 64;
    localparam int IDX_W          = 3;
    localparam int ROW_W          = 52;   // 32b coef * 17b value, four terms
    localparam int DIV_W          = 64;   // magnitude width handled by the divider

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;   // magnitude
        logic [DIV_W-1:0] den;   // magnitude, non-zero
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

endpackage

>>> hdl/spra_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spra_in_if / spra_out_if
// Valid/ready channels carrying point items and results.
// ----------------------------------------------------------------------------
interface spra_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] ref_x;
    logic [15:0] ref_y;
    logic [15:0] other_x;
    logic        last_point;

    modport source (output valid, ref_x, ref_y, other_x, last_point, input ready);
    modport sink   (input valid, ref_x, ref_y, other_x, last_point, output ready);
endinterface

interface spra_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0]        point_disparity;
    logic               point_valid;
    logic signed [31:0] avg_x;
    logic signed [31:0] avg_y;
    logic signed [31:0] avg_z;
    logic [15:0]        avg_disparity;
    logic               avg_valid;

    modport source (output valid, point_x, point_y, point_z, point_disparity,
                    point_valid, avg_x, avg_y, avg_z, avg_disparity, avg_valid,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, point_disparity,
                    point_valid, avg_x, avg_y, avg_z, avg_disparity, avg_valid,
                    output ready);
endinterface

>>> hdl/spra_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spra_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spra_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  spra_pkg::div_req_t  req,
    output spra_pkg::div_rsp_t  rsp
);

    localparam int W  = spra_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

>>> hdl/stereo_point_reproject_average_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_point_reproject_average_unit
// Reprojects matched stereo points through a 4x4 Q matrix and averages them.
// ----------------------------------------------------------------------------
// One item at a time. A single 32x17 multiplier runs the sixteen matrix MACs
// (one per cycle), then a shared one-bit-per-cycle 64-bit divider forms X, Y
// and Z and, on a last point, the four averages. A point whose divisor W is
// zero skips the three divisions, and the averages are formed only for a
// non-empty set. The result is held until out.ready takes it, and in.ready
// rises on the cycle after that transfer; in.ready is high only while idle.
// The coefficient scale cancels in the division, so the fraction width of
// the Q words does not enter the logic.
module stereo_point_reproject_average_unit #(
    parameter int MAX_POINTS     = spra_pkg::DefMaxPoints
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [spra_pkg::IDX_W-1:0]    cfg_index,
    input  logic [spra_pkg::REG_W-1:0]    cfg_data,
    spra_in_if.sink                       in,
    spra_out_if.source                    out
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int RW    = spra_pkg::ROW_W;
    localparam int DW    = spra_pkg::DIV_W;

    logic [spra_pkg::REG_W-1:0] q_reg [spra_pkg::NUM_REGS];

    spra_pkg::state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;       // MAC index row*4+col, or div index
    logic [15:0] rx_reg, ry_reg, disp_reg;
    logic        last_reg;
    logic signed [RW-1:0] acc_reg, acc_next;
    logic signed [RW-1:0] row_reg [3];
    logic signed [31:0] p_reg [3];
    logic signed [31:0] a_reg [3];
    logic [15:0] avgd_reg;
    logic        pval_reg, aval_reg;
    logic signed [39:0] sx_reg, sy_reg, sz_reg;
    logic [23:0] sd_reg;
    logic [CNT_W-1:0] cnt_reg;

    spra_pkg::div_req_t dreq;
    spra_pkg::div_rsp_t drsp;
    logic        dneg_reg;

    spra_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // ---- MAC datapath ------------------------------------------------------
    logic [1:0]  mrow, mcol;
    logic [31:0] cword;
    logic signed [16:0] vec;
    logic signed [48:0] prod;
    assign mrow = step_reg[3:2];
    assign mcol = step_reg[1:0];
    always_comb
    begin
        logic [spra_pkg::REG_W-1:0] r;
        r     = q_reg[{mrow, mcol[1]}];
        cword = mcol[0] ? r[31:0] : r[63:32];
        case (mcol)
            2'd0:    vec = signed'({1'b0, rx_reg});
            2'd1:    vec = signed'({1'b0, ry_reg});
            2'd2:    vec = signed'({1'b0, disp_reg});
            default: vec = 17'sd16;
        endcase
    end
    assign prod = signed'(cword) * vec;

    // ---- divider operand selection ----------------------------------------
    logic signed [RW-1:0] num_s, den_s;
    logic signed [39:0]   sum_sel;
    logic [DW-1:0] num_mag, den_mag;
    logic          num_neg, den_neg;
    always_comb
    begin
        num_s = row_reg[(step_reg[1:0] == 2'd3) ? 2'd0 : step_reg[1:0]];
        den_s = acc_reg;   // row 3 (W) stays in the accumulator
        case (step_reg[1:0])
            2'd0:    sum_sel = sx_reg;
            2'd1:    sum_sel = sy_reg;
            2'd2:    sum_sel = sz_reg;
            default: sum_sel = 40'(sd_reg);
        endcase
        num_neg = 1'b0;
        den_neg = 1'b0;
        if (state_reg == spra_pkg::ST_AVG_START)
        begin
            num_neg = sum_sel[39];
            num_mag = num_neg ? DW'(-sum_sel) : DW'(sum_sel);
            den_mag = DW'(cnt_reg);
        end
        else
        begin
            num_neg = num_s[RW-1];
            den_neg = den_s[RW-1];
            num_mag = num_neg ? DW'(-num_s) << 8 : DW'(num_s) << 8;
            den_mag = den_neg ? DW'(-den_s) : DW'(den_s);
        end
    end

    // ---- saturation of signed quotient -------------------------------------
    logic signed [31:0] qsat;
    always_comb
    begin
        if (dneg_reg)
            qsat = (drsp.quo >= DW'(64'h8000_0000)) ? 32'sh8000_0000
                                                    : 32'(-$signed(drsp.quo[32:0]));
        else
            qsat = (drsp.quo > DW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                   : signed'(drsp.quo[31:0]);
    end

    // ---- sequencer -----------------------------------------------------------
    // W is still in the accumulator here; pval_reg may belong to the last item
    logic accum_ok;
    assign accum_ok = (acc_reg != '0) && (cnt_reg < CNT_W'(MAX_POINTS));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        dreq.start = 1'b0;
        dreq.num   = num_mag;
        dreq.den   = den_mag;
        case (state_reg)
            spra_pkg::ST_IDLE:
                if (in.valid)
                begin
                    state_next = spra_pkg::ST_MAC;
                    step_next  = '0;
                    acc_next   = '0;
                end
            spra_pkg::ST_MAC:
            begin
                acc_next  = (mcol == 2'd0 ? RW'(0) : acc_reg) + RW'(prod);
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd15)
                begin
                    state_next = spra_pkg::ST_DIV_START;
                    step_next  = '0;
                end
            end
            spra_pkg::ST_DIV_START:
            begin
                if (acc_reg == '0 || step_reg[1:0] == 2'd3)
                    state_next = last_reg ? spra_pkg::ST_AVG_START : spra_pkg::ST_OUT;
                else
                begin
                    dreq.start = 1'b1;
                    state_next = spra_pkg::ST_DIV_WAIT;
                end
                if (acc_reg == '0 || step_reg[1:0] == 2'd3)
                    step_next = '0;
            end
            spra_pkg::ST_DIV_WAIT:
                if (drsp.done)
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = spra_pkg::ST_DIV_START;
                end
            spra_pkg::ST_AVG_START:
            begin
                if (cnt_reg == '0 || step_reg[2])
                    state_next = spra_pkg::ST_OUT;
                else
                begin
                    dreq.start = 1'b1;
                    state_next = spra_pkg::ST_AVG_WAIT;
                end
            end
            spra_pkg::ST_AVG_WAIT:
                if (drsp.done)
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = spra_pkg::ST_AVG_START;
                end
            spra_pkg::ST_OUT:
                if (out.ready)
                    state_next = spra_pkg::ST_IDLE;
            default: state_next = spra_pkg::ST_IDLE;
        endcase
    end

    assign in.ready  = (state_reg == spra_pkg::ST_IDLE);
    assign out.valid = (state_reg == spra_pkg::ST_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spra_pkg::ST_IDLE;
            step_reg  <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sz_reg    <= '0;
            sd_reg    <= '0;
            cnt_reg   <= '0;
            for (int i = 0; i < spra_pkg::NUM_REGS; i++)
                q_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_we)
                q_reg[cfg_index] <= cfg_data;
            // accumulate once the point is complete, before the averages
            if (state_reg == spra_pkg::ST_DIV_START && state_next != spra_pkg::ST_DIV_WAIT
                && accum_ok)
            begin
                sx_reg  <= sx_reg + 40'(p_reg[0]);
                sy_reg  <= sy_reg + 40'(p_reg[1]);
                sz_reg  <= sz_reg + 40'(p_reg[2]);
                sd_reg  <= sd_reg + 24'(disp_reg);
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == spra_pkg::ST_OUT && out.ready && last_reg)
            begin
                sx_reg  <= '0;
                sy_reg  <= '0;
                sz_reg  <= '0;
                sd_reg  <= '0;
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (state_reg == spra_pkg::ST_IDLE && in.valid)
        begin
            rx_reg   <= in.ref_x;
            ry_reg   <= in.ref_y;
            disp_reg <= (in.ref_x >= in.other_x) ? in.ref_x - in.other_x
                                                 : in.other_x - in.ref_x;
            last_reg <= in.last_point;
            aval_reg <= 1'b0;
            avgd_reg <= '0;
            for (int i = 0; i < 3; i++)
                a_reg[i] <= '0;
        end
        if (state_reg == spra_pkg::ST_MAC && mcol == 2'd3 && mrow != 2'd3)
            row_reg[mrow] <= acc_next;
        if (state_reg == spra_pkg::ST_DIV_START && step_reg == 4'd0)
        begin
            pval_reg <= (acc_reg != '0);
            if (acc_reg == '0)
                for (int i = 0; i < 3; i++)
                    p_reg[i] <= row_reg[i][RW-1] ? 32'sh8000_0000 :
                                (row_reg[i] == '0 ? 32'sd0 : 32'sh7FFF_FFFF);
        end
        if (dreq.start)
            dneg_reg <= num_neg ^ den_neg;
        if (state_reg == spra_pkg::ST_DIV_WAIT && drsp.done)
            p_reg[step_reg[1:0]] <= qsat;
        if (state_reg == spra_pkg::ST_AVG_START && cnt_reg != '0 && step_reg == 4'd0)
            aval_reg <= 1'b1;
        if (state_reg == spra_pkg::ST_AVG_WAIT && drsp.done)
        begin
            if (step_reg[1:0] == 2'd3)
                avgd_reg <= drsp.quo[15:0];
            else
                a_reg[step_reg[1:0]] <= dneg_reg ? 32'(-drsp.quo[39:0]) : drsp.quo[31:0];
        end
    end

    assign out.point_x         = p_reg[0];
    assign out.point_y         = p_reg[1];
    assign out.point_z         = p_reg[2];
    assign out.point_disparity = disp_reg;
    assign out.point_valid     = pval_reg;
    assign out.avg_x           = a_reg[0];
    assign out.avg_y           = a_reg[1];
    assign out.avg_z           = a_reg[2];
    assign out.avg_disparity   = avgd_reg;
    assign out.avg_valid       = aval_reg;

endmodule

>>> hdl/spra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spra_checker
// Port-level checks on the reprojection averager, bound to the top level.
// ----------------------------------------------------------------------------
module spra_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic point_valid,
    input logic avg_valid
);

    // one item in flight: no input taken while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input ready while result held");

    // an accepted item cannot produce its result on the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");

    // average flag held while the result is stalled
    a_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(avg_valid))
        else $error("avg_valid changed while stalled");

    // valid and point flag held while the result is stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(point_valid)))
        else $error("result dropped while stalled");

endmodule

bind stereo_point_reproject_average_unit spra_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .point_valid(out.point_valid), .avg_valid(out.avg_valid)
);
